@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/dtfp_pkg.sv @@
// shared types, constants and power tables for the decimal text converter
// no dependencies; used by the top level and the divider pipeline
package dtfp_pkg;

    // parameter defaults
    localparam int FRAC_BITS_DEF       = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 9;
    localparam int VALUE_BITS_DEF      = 48;

    // fixed widths
    localparam int CHAR_W          = 8;
    localparam int MANT_W          = 64;
    localparam int CNT_W           = 4;
    localparam int DIV_W           = 35;   // holds 5^15
    localparam int POW_W           = 50;   // holds 10^15
    localparam int QBITS_PER_STAGE = 4;    // quotient bits retired per divider stage
    localparam int POW_ENTRIES     = 2 ** CNT_W;

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

    // scan phase of the token parser
    typedef enum logic [1:0] {
        PH_WS,
        PH_SIGNED,
        PH_BODY,
        PH_STOP
    } phase_t;

    // per-token flags carried alongside the arithmetic
    typedef struct packed {
        logic negative;
        logic well_formed;
        logic saturated;
    } side_t;

    // ten to the k
    localparam logic [POW_W-1:0] POW10_TABLE [POW_ENTRIES] = '{
        50'd1,
        50'd10,
        50'd100,
        50'd1000,
        50'd10000,
        50'd100000,
        50'd1000000,
        50'd10000000,
        50'd100000000,
        50'd1000000000,
        50'd10000000000,
        50'd100000000000,
        50'd1000000000000,
        50'd10000000000000,
        50'd100000000000000,
        50'd1000000000000000
    };

    // five to the k
    localparam logic [DIV_W-1:0] POW5_TABLE [POW_ENTRIES] = '{
        35'd1,
        35'd5,
        35'd25,
        35'd125,
        35'd625,
        35'd3125,
        35'd15625,
        35'd78125,
        35'd390625,
        35'd1953125,
        35'd9765625,
        35'd48828125,
        35'd244140625,
        35'd1220703125,
        35'd6103515625,
        35'd30517578125
    };

endpackage

@@ hdl/decimal_text_to_fixed_point_unit.sv @@
// decimal text to signed fixed point converter, top level
// depends on dtfp_pkg and dtfp_div_pipe
//
// Takes one character of a decimal token per transfer, with last_char marking the end,
// and returns one result per token: fixed_value with FRAC_BITS fraction bits, rounded
// half up and saturated to VALUE_BITS, plus well_formed and overflowed. One character is
// taken every cycle while in_ready is high. Once a token's last character is taken, the token
// passes through the capture register, one register per divider stage, the divider's
// quotient register and the output register before its result is offered. The divider
// retires up to four quotient bits per stage while dividing by 5^k. While a result is held
// by out_ready low, the divider pipeline stands still; characters keep being taken until the
// capture register holds a token, and from then on in_ready stays low, for every character,
// until the output moves again.
module decimal_text_to_fixed_point_unit #(
    parameter int FRAC_BITS       = dtfp_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dtfp_pkg::MAX_FRAC_DIGITS_DEF,
    parameter int VALUE_BITS      = dtfp_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dtfp_pkg::CHAR_W-1:0]   char_code,
    input  logic                          last_char,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_BITS-1:0]  fixed_value,
    output logic                          well_formed,
    output logic                          overflowed
);

    localparam int MANT_W = dtfp_pkg::MANT_W;
    localparam int CNT_W  = dtfp_pkg::CNT_W;
    localparam int YW     = MANT_W + FRAC_BITS + 1;
    localparam int PROD_W = MANT_W + 4;

    // scanner state
    dtfp_pkg::phase_t     phase_reg, phase_next;
    logic [MANT_W-1:0]    mant_reg, mant_next;
    logic [CNT_W-1:0]     frac_cnt_reg, frac_cnt_next;
    logic                 point_reg, point_next;
    logic                 neg_reg, neg_next;
    logic                 need_digit_reg, need_digit_next;
    logic                 malformed_reg, malformed_next;
    logic                 sat_reg, sat_next;

    // capture stage
    logic                 cap_vld_reg;
    logic [MANT_W-1:0]    cap_mant_reg;
    logic [CNT_W-1:0]     cap_cnt_reg;
    dtfp_pkg::side_t      cap_side_reg;

    // output stage
    logic                 out_valid_reg;
    logic [VALUE_BITS-1:0] fixed_value_reg, fixed_value_next;
    logic                 well_formed_reg;
    logic                 overflowed_reg, overflowed_next;

    logic                 adv;
    logic                 in_xfer;
    logic                 cap_load;
    logic                 is_ws, is_sign, is_digit, is_point;
    logic                 body_act, sign_act, digit_act, point_act, stop_act;
    logic [PROD_W-1:0]    mul_sum;
    logic                 mul_ovf;
    logic                 wf_next;

    logic                 quot_vld;
    logic [YW-1:0]        quot;
    dtfp_pkg::side_t      quot_side;
    logic [YW-1:0]        lim;
    logic                 sat_v;
    logic [VALUE_BITS-1:0] mag;

    // handshake: everything past the scanner moves when the output register is free
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = !cap_vld_reg || adv;
    assign in_xfer  = in_valid && in_ready;
    assign cap_load = in_xfer && last_char;

    // character classes
    assign is_ws    = char_code inside {[dtfp_pkg::CH_TAB:dtfp_pkg::CH_CR], dtfp_pkg::CH_SPACE};
    assign is_sign  = char_code inside {dtfp_pkg::CH_PLUS, dtfp_pkg::CH_MINUS};
    assign is_digit = char_code inside {[dtfp_pkg::CH_ZERO:dtfp_pkg::CH_NINE]};
    assign is_point = (char_code == dtfp_pkg::CH_POINT);

    // which kind of step this character makes
    always_comb
    begin
        case (phase_reg)
            dtfp_pkg::PH_WS:     body_act = !is_ws && !is_sign;
            dtfp_pkg::PH_SIGNED: body_act = 1'b1;
            dtfp_pkg::PH_BODY:   body_act = 1'b1;
            default:             body_act = 1'b0;
        endcase
    end

    assign sign_act  = (phase_reg == dtfp_pkg::PH_WS) && is_sign;
    assign digit_act = body_act && is_digit;
    assign point_act = body_act && is_point && !point_reg;
    assign stop_act  = body_act && !digit_act && !point_act;

    // next scan phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            dtfp_pkg::PH_WS:
            begin
                if (sign_act)
                    phase_next = dtfp_pkg::PH_SIGNED;
                else if (digit_act || point_act)
                    phase_next = dtfp_pkg::PH_BODY;
                else if (stop_act)
                    phase_next = dtfp_pkg::PH_STOP;
            end
            dtfp_pkg::PH_SIGNED, dtfp_pkg::PH_BODY:
            begin
                if (digit_act || point_act)
                    phase_next = dtfp_pkg::PH_BODY;
                else
                    phase_next = dtfp_pkg::PH_STOP;
            end
            default:
                phase_next = dtfp_pkg::PH_STOP;
        endcase
    end

    // mantissa times ten plus digit, sticky at all ones on overflow
    assign mul_sum = {1'b0, mant_reg, 3'b000} + {3'b000, mant_reg, 1'b0}
                   + {{MANT_W{1'b0}}, char_code[3:0]};
    assign mul_ovf = |mul_sum[PROD_W-1:MANT_W];

    // scanner datapath
    always_comb
    begin
        mant_next       = mant_reg;
        frac_cnt_next   = frac_cnt_reg;
        point_next      = point_reg;
        neg_next        = neg_reg;
        need_digit_next = need_digit_reg;
        malformed_next  = malformed_reg;
        sat_next        = sat_reg;

        if (sign_act)
            neg_next = (char_code == dtfp_pkg::CH_MINUS);

        if (digit_act)
        begin
            need_digit_next = 1'b0;
            // fraction digits past the limit only count for form
            if (!point_reg || (frac_cnt_reg < CNT_W'(MAX_FRAC_DIGITS)))
            begin
                if (point_reg)
                    frac_cnt_next = frac_cnt_reg + CNT_W'(1);
                if (mul_ovf)
                begin
                    mant_next = '1;
                    sat_next  = 1'b1;
                end
                else
                begin
                    mant_next = mul_sum[MANT_W-1:0];
                end
            end
        end

        // a point with no digit before it is malformed
        if (point_act)
        begin
            if (phase_reg != dtfp_pkg::PH_BODY)
                malformed_next = 1'b1;
            point_next      = 1'b1;
            need_digit_next = 1'b1;
        end

        if (stop_act)
            malformed_next = 1'b1;
    end

    assign wf_next = !malformed_next && (phase_next == dtfp_pkg::PH_BODY) && !need_digit_next;

    // scanner registers, cleared after the last character of each token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= dtfp_pkg::PH_WS;
            mant_reg       <= '0;
            frac_cnt_reg   <= '0;
            point_reg      <= 1'b0;
            neg_reg        <= 1'b0;
            need_digit_reg <= 1'b0;
            malformed_reg  <= 1'b0;
            sat_reg        <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (last_char)
            begin
                phase_reg      <= dtfp_pkg::PH_WS;
                mant_reg       <= '0;
                frac_cnt_reg   <= '0;
                point_reg      <= 1'b0;
                neg_reg        <= 1'b0;
                need_digit_reg <= 1'b0;
                malformed_reg  <= 1'b0;
                sat_reg        <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                mant_reg       <= mant_next;
                frac_cnt_reg   <= frac_cnt_next;
                point_reg      <= point_next;
                neg_reg        <= neg_next;
                need_digit_reg <= need_digit_next;
                malformed_reg  <= malformed_next;
                sat_reg        <= sat_next;
            end
        end
    end

    // capture stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_vld_reg <= 1'b0;
        else if (cap_load)
            cap_vld_reg <= 1'b1;
        else if (adv)
            cap_vld_reg <= 1'b0;
    end

    // capture stage payload
    always_ff @(posedge clk)
    begin
        if (cap_load)
        begin
            cap_mant_reg <= mant_next;
            cap_cnt_reg  <= frac_cnt_next;
            cap_side_reg <= '{negative: neg_next, well_formed: wf_next, saturated: sat_next};
        end
    end

    // scaling and division
    dtfp_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_vld    (cap_vld_reg),
        .in_mant   (cap_mant_reg),
        .in_cnt    (cap_cnt_reg),
        .in_side   (cap_side_reg),
        .quot_vld  (quot_vld),
        .quot      (quot),
        .quot_side (quot_side)
    );

    // clamp to the signed range and apply the sign
    always_comb
    begin
        lim              = (YW'(1) << (VALUE_BITS - 1)) - YW'(!quot_side.negative);
        sat_v            = (quot > lim);
        mag              = sat_v ? lim[VALUE_BITS-1:0] : quot[VALUE_BITS-1:0];
        fixed_value_next = quot_side.negative ? ('0 - mag) : mag;
        overflowed_next  = quot_side.saturated || sat_v;
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= quot_vld;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fixed_value_reg <= fixed_value_next;
            well_formed_reg <= quot_side.well_formed;
            overflowed_reg  <= overflowed_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign fixed_value = fixed_value_reg;
    assign well_formed = well_formed_reg;
    assign overflowed  = overflowed_reg;

endmodule

@@ hdl/dtfp_div_pipe.sv @@
// scaling and long-division pipeline: mantissa * 2^FRAC_BITS / 10^k, rounded half up
// depends on dtfp_pkg; instantiated by decimal_text_to_fixed_point_unit
module dtfp_div_pipe #(
    parameter int FRAC_BITS = dtfp_pkg::FRAC_BITS_DEF,
    localparam int YW = dtfp_pkg::MANT_W + FRAC_BITS + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_vld,
    input  logic [dtfp_pkg::MANT_W-1:0] in_mant,
    input  logic [dtfp_pkg::CNT_W-1:0]  in_cnt,
    input  dtfp_pkg::side_t             in_side,
    output logic                        quot_vld,
    output logic [YW-1:0]               quot,
    output dtfp_pkg::side_t             quot_side
);

    localparam int SUM_W = YW + 1;
    localparam int DIV_W = dtfp_pkg::DIV_W;
    localparam int QPS   = dtfp_pkg::QBITS_PER_STAGE;
    localparam int NSTEP = (YW + QPS - 1) / QPS;
    localparam int SH_W  = dtfp_pkg::CNT_W + 1;

    // stage registers, index 0 holds the scaled dividend
    logic [NSTEP-1:0]      st_vld_reg;
    logic [YW-1:0]         st_w_reg    [NSTEP];
    logic [DIV_W-1:0]      st_r_reg    [NSTEP];
    logic [DIV_W-1:0]      st_d_reg    [NSTEP];
    dtfp_pkg::side_t       st_side_reg [NSTEP];
    logic                  q_vld_reg;
    logic [YW-1:0]         q_w_reg;
    dtfp_pkg::side_t       q_side_reg;

    // step outputs
    logic [YW-1:0]         nx_w [NSTEP];
    logic [DIV_W-1:0]      nx_r [NSTEP-1];

    // scaled dividend: (m * 2^(F+1) + 10^k) >> (k+1), then divide by 5^k
    logic [SUM_W-1:0]      y_sum;
    logic [SUM_W-1:0]      y_shift;
    logic [SH_W-1:0]       y_amt;

    assign y_sum   = {1'b0, in_mant, {(FRAC_BITS + 1){1'b0}}}
                   + SUM_W'(dtfp_pkg::POW10_TABLE[in_cnt]);
    assign y_amt   = {1'b0, in_cnt} + SH_W'(1);
    assign y_shift = y_sum >> y_amt;

    // restoring division, a few quotient bits per stage; quotient shifts in at the bottom
    for (genvar s = 0; s < NSTEP; s++)
    begin : g_step
        logic [YW-1:0]    w_out;
        logic [DIV_W-1:0] r_out;

        always_comb
        begin
            logic [DIV_W:0] trial;
            w_out = st_w_reg[s];
            r_out = st_r_reg[s];
            trial = '0;
            for (int j = 0; j < QPS; j++)
            begin
                if (s * QPS + j < YW)
                begin
                    trial = {r_out, w_out[YW-1]};
                    w_out = {w_out[YW-2:0], 1'b0};
                    if (trial >= {1'b0, st_d_reg[s]})
                    begin
                        trial    = trial - {1'b0, st_d_reg[s]};
                        w_out[0] = 1'b1;
                    end
                    r_out = trial[DIV_W-1:0];
                end
            end
        end

        assign nx_w[s] = w_out;

        if (s < NSTEP - 1)
        begin : g_rem
            assign nx_r[s] = r_out;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg <= '0;
            q_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            st_vld_reg <= {st_vld_reg[NSTEP-2:0], in_vld};
            q_vld_reg  <= st_vld_reg[NSTEP-1];
        end
    end

    // payload, frozen while the output stalls
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_w_reg[0]    <= y_shift[YW-1:0];
            st_r_reg[0]    <= '0;
            st_d_reg[0]    <= dtfp_pkg::POW5_TABLE[in_cnt];
            st_side_reg[0] <= in_side;
            for (int s = 0; s < NSTEP - 1; s++)
            begin
                st_w_reg[s+1]    <= nx_w[s];
                st_r_reg[s+1]    <= nx_r[s];
                st_d_reg[s+1]    <= st_d_reg[s];
                st_side_reg[s+1] <= st_side_reg[s];
            end
            q_w_reg    <= nx_w[NSTEP-1];
            q_side_reg <= st_side_reg[NSTEP-1];
        end
    end

    assign quot_vld  = q_vld_reg;
    assign quot      = q_w_reg;
    assign quot_side = q_side_reg;

endmodule

@@ hdl/dtfp_checker.sv @@
// port-level checks for decimal_text_to_fixed_point_unit, attached by bind
// depends on assert_macros.svh and dtfp_pkg
`include "assert_macros.svh"

module dtfp_checker #(
    parameter int VALUE_BITS = dtfp_pkg::VALUE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [dtfp_pkg::CHAR_W-1:0]   char_code,
    input logic                          last_char,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [VALUE_BITS-1:0]  fixed_value,
    input logic                          well_formed,
    input logic                          overflowed
);

    logic [7:0] pend_reg;
    logic       tok_in;
    logic       res_out;

    assign tok_in  = in_valid && in_ready && last_char;
    assign res_out = out_valid && out_ready;

    // tokens whose result has not been taken yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (tok_in && !res_out)
            pend_reg <= pend_reg + 8'd1;
        else if (res_out && !tok_in)
            pend_reg <= pend_reg - 8'd1;
    end

    // a stalled result holds its value
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(fixed_value) && $stable(well_formed) && $stable(overflowed), "result changed while stalled")

    // with no result waiting the input side never blocks
    `ASSERT_IMPLIES(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input blocked with empty output")

    // every result belongs to a token whose last character was taken
    `ASSERT_IMPLIES(a_no_extra_result, clk, rst_n, out_valid, pend_reg != 8'd0, "result with no pending token")

    // a character that is not the last never produces a result on its own
    `ASSERT_NEXT(a_no_early_result, clk, rst_n, pend_reg == 8'd0 && !tok_in, !out_valid, "result without a finished token")

endmodule

bind decimal_text_to_fixed_point_unit dtfp_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_dtfp_checker (.*);

@@ verif/decimal_text_to_fixed_point_unit_tb.sv @@
// testbench for decimal_text_to_fixed_point_unit: directed and random numeric tokens
// predicts each token's fixed-point result in a scoreboard class and checks the outputs
// depends on dtfp_pkg and the unit's rtl
module decimal_text_to_fixed_point_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAR_W       = dtfp_pkg::CHAR_W;
    localparam int FRAC_W       = dtfp_pkg::FRAC_BITS_DEF;
    localparam int MAX_FRAC     = dtfp_pkg::MAX_FRAC_DIGITS_DEF;
    localparam int VALUE_W      = dtfp_pkg::VALUE_BITS_DEF;
    localparam int RANDOM_CHARS = 1150;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [CHAR_W-1:0] CH_LETTER_E = 8'd101;

    // tracks token scan state and the results still owed by the unit
    class fixed_point_scoreboard;
        typedef struct {
            logic [VALUE_W-1:0] value;
            bit                 wf;
            bit                 ov;
        } fixed_result_t;

        fixed_result_t results_due[$];
        int            errors;

        dtfp_pkg::phase_t phase;
        logic [63:0]      mant;
        logic [3:0]       fcount;
        bit               point, neg, need_digit, malformed, sat;

        function new();
            errors = 0;
            clear_token();
        endfunction

        function void clear_token();
            phase      = dtfp_pkg::PH_WS;
            mant       = '0;
            fcount     = '0;
            point      = 1'b0;
            neg        = 1'b0;
            need_digit = 1'b0;
            malformed  = 1'b0;
            sat        = 1'b0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // accumulate one digit, sticking at the top of the 64-bit range
        function void take_digit(int unsigned d);
            if (point)
            begin
                if (fcount >= MAX_FRAC)
                    return;
                fcount = fcount + 4'd1;
            end
            if (mant > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10)
            begin
                mant = 64'hFFFF_FFFF_FFFF_FFFF;
                sat  = 1'b1;
            end
            else
                mant = mant * 64'd10 + 64'(d);
        endfunction

        // digits, a single point, anything else stops the scan
        function void body_char(logic [CHAR_W-1:0] c);
            if (c >= dtfp_pkg::CH_ZERO && c <= dtfp_pkg::CH_NINE)
            begin
                take_digit(c - dtfp_pkg::CH_ZERO);
                need_digit = 1'b0;
                phase      = dtfp_pkg::PH_BODY;
            end
            else if (c == dtfp_pkg::CH_POINT && !point)
            begin
                if (phase != dtfp_pkg::PH_BODY)
                    malformed = 1'b1;
                point      = 1'b1;
                need_digit = 1'b1;
                phase      = dtfp_pkg::PH_BODY;
            end
            else
            begin
                phase     = dtfp_pkg::PH_STOP;
                malformed = 1'b1;
            end
        endfunction

        // mantissa over 10^fcount as fixed point, rounded half up and clamped
        function logic [VALUE_W-1:0] scaled_value(output bit clipped);
            logic [63:0] p, q, r, f, mag, lim;
            bit          rnd;
            p = 64'd1;
            for (int k = 0; k < fcount; k++)
                p = p * 64'd10;
            q = mant / p;
            r = mant % p;
            f = '0;
            for (int i = 0; i < FRAC_W; i++)
            begin
                r = r << 1;
                f = f << 1;
                if (r >= p)
                begin
                    r    = r - p;
                    f[0] = 1'b1;
                end
            end
            rnd     = ((r << 1) >= p);
            lim     = (64'd1 << (VALUE_W - 1)) - (neg ? 64'd0 : 64'd1);
            clipped = 1'b0;
            if (q > (lim >> FRAC_W))
            begin
                clipped = 1'b1;
                mag     = lim;
            end
            else
            begin
                mag = (q << FRAC_W) + f + 64'(rnd);
                if (mag > lim)
                begin
                    clipped = 1'b1;
                    mag     = lim;
                end
            end
            if (neg)
                mag = 64'd0 - mag;
            return mag[VALUE_W-1:0];
        endfunction

        // one accepted character; the last one of a token owes a result
        function void note_char(logic [CHAR_W-1:0] c, logic last);
            fixed_result_t e;
            bit            clipped;
            if (phase == dtfp_pkg::PH_WS)
            begin
                if ((c >= dtfp_pkg::CH_TAB && c <= dtfp_pkg::CH_CR) || c == dtfp_pkg::CH_SPACE)
                begin
                    // leading whitespace is skipped
                end
                else if (c == dtfp_pkg::CH_MINUS || c == dtfp_pkg::CH_PLUS)
                begin
                    neg   = (c == dtfp_pkg::CH_MINUS);
                    phase = dtfp_pkg::PH_SIGNED;
                end
                else
                    body_char(c);
            end
            else if (phase != dtfp_pkg::PH_STOP)
                body_char(c);
            if (last)
            begin
                e.value = scaled_value(clipped);
                e.wf    = !malformed && phase == dtfp_pkg::PH_BODY && !need_digit;
                e.ov    = sat || clipped;
                results_due.push_back(e);
                clear_token();
            end
        endfunction

        // compare one result transfer against the oldest prediction
        function void check_result(logic [VALUE_W-1:0] value, logic wf, logic ov);
            fixed_result_t e;
            if (results_due.size() == 0)
            begin
                $error("result transfer with no token pending: fixed_value %0d",
                       $signed(value));
                errors++;
                return;
            end
            e = results_due.pop_front();
            if (value !== e.value)
            begin
                $error("fixed_value: expected %0d, got %0d", $signed(e.value), $signed(value));
                errors++;
            end
            if (wf !== e.wf)
            begin
                $error("well_formed: expected %0d, got %0d", e.wf, wf);
                errors++;
            end
            if (ov !== e.ov)
            begin
                $error("overflowed: expected %0d, got %0d", e.ov, ov);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [CHAR_W-1:0]         char_code;
    logic                      last_char;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [VALUE_W-1:0] fixed_value;
    logic                      well_formed;
    logic                      overflowed;

    fixed_point_scoreboard sb = new();
    logic [CHAR_W-1:0]     token_chars[$];
    int                    chars_sent = 0;
    int                    cycles = 0;
    bit                    calm = 1'b0;
    logic                  hold_off = 1'b0;

    decimal_text_to_fixed_point_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .last_char   (last_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fixed_value (fixed_value),
        .well_formed (well_formed),
        .overflowed  (overflowed)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // digit run length: mostly short, some long enough to saturate
    function automatic int run_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 4);
        else if (r < 90)
            return $urandom_range(5, 10);
        return $urandom_range(11, 22);
    endfunction

    function automatic logic [CHAR_W-1:0] ws_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? dtfp_pkg::CH_SPACE : dtfp_pkg::CH_TAB + CHAR_W'(r);
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char();
        return dtfp_pkg::CH_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    // one character transfer, with a random gap before it
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic l);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_char(c, l);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // mostly well-formed tokens with random content, some broken, some noise
    task automatic build_token();
        int  kind, n_int, n_frac, pos;
        bit  broken;
        logic [CHAR_W-1:0] odd;
        token_chars.delete();
        kind   = $urandom_range(0, 99);
        broken = (kind < 30);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 5))
                token_chars.push_back(CHAR_W'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                token_chars.push_back(ws_char());
        case ($urandom_range(0, 2))
            0: token_chars.push_back(dtfp_pkg::CH_MINUS);
            1: token_chars.push_back(dtfp_pkg::CH_PLUS);
            default: ;
        endcase
        n_int = (broken && $urandom_range(0, 3) == 0) ? 0 : run_len();
        repeat (n_int)
            token_chars.push_back(digit_char());
        if ($urandom_range(0, 1) == 1 || n_int == 0)
        begin
            token_chars.push_back(dtfp_pkg::CH_POINT);
            n_frac = (broken && $urandom_range(0, 3) == 0) ? 0 : run_len();
            repeat (n_frac)
                token_chars.push_back(digit_char());
        end
        // corrupt a broken token with a stray character
        if (broken && $urandom_range(0, 1) == 1)
        begin
            case ($urandom_range(0, 5))
                0: odd = dtfp_pkg::CH_POINT;
                1: odd = dtfp_pkg::CH_PLUS;
                2: odd = dtfp_pkg::CH_MINUS;
                3: odd = dtfp_pkg::CH_SPACE;
                4: odd = CH_LETTER_E;
                default: odd = CHAR_W'($urandom_range(0, 255));
            endcase
            pos = $urandom_range(0, token_chars.size());
            token_chars.insert(pos, odd);
        end
        if (token_chars.size() == 0)
            token_chars.push_back(ws_char());
    endtask

    // stimulus
    initial
    begin
        int random_sent;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_code = '0;
        last_char = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sign handling, point corner cases, stray characters, clamping
        send_text("-0");
        send_text("+.5");
        send_text("7.");
        send_text("1..");
        send_text("--1");
        send_text(" ");
        send_text("\t-");
        send_text("9999999999");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);

        // random tokens
        random_sent = 0;
        while (random_sent < RANDOM_CHARS)
        begin
            build_token();
            calm = ($urandom_range(0, 3) == 0);
            foreach (token_chars[i])
                send_char(token_chars[i], i == token_chars.size() - 1);
            random_sent += token_chars.size();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result side: check each transfer, stall at random
    initial
    begin
        int stall_left, run_left;
        stall_left = 0;
        run_left   = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(fixed_value, well_formed, overflowed);
            if (hold_off)
                out_ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else if ($urandom_range(0, 7) == 0)
                    run_left = $urandom_range(50, 200);
                else
                    stall_left = idle_len();
            end
        end
    end

    // long receiver hold so the unit fills up and stalls its input
    initial
    begin
        while (chars_sent < HOLD_AFTER)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // timeout
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
